// File: sv/fqrm_pkg.sv
// Shared types and constants for the FIFO queue with remove-by-identifier.
// No dependencies; every other file imports this package.
package fqrm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = AddrW + 1;
  localparam int CountPortW = 5;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REM    = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] tag;
    logic        vip;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t ent;
  } req_t;

  typedef struct packed {
    status_e          status;
    entry_t           served;
    logic [CntW-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// File: sv/fqrm_store.sv
// Entry store: one write port, one read port with registered read data.
// Depends on fqrm_pkg.
module fqrm_store import fqrm_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[mem_req_i.raddr];
  end

endmodule

// File: sv/fqrm_seq.sv
// Sequencer: walks the entry store one entry per cycle for search and gap closing.
// Depends on fqrm_pkg; drives fqrm_store through a mem_req_t.
module fqrm_seq import fqrm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  req_t     req_i,
  output logic     idle_o,
  output logic     rsp_valid_o,
  input  logic     rsp_take_i,
  output rsp_t     rsp_o,
  output mem_req_t mem_req_o,
  input  entry_t   mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] wr_idx_q, wr_idx_d;
  entry_t           served_q, served_d;
  status_e          status_q, status_d;
  logic             hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    idx_q    <= idx_d;
    wr_idx_q <= wr_idx_d;
    served_q <= served_d;
    status_q <= status_d;
  end

  assign hit = (req_q.op == OP_DEQ) || (mem_rdata_i.id == req_q.ent.id);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    wr_idx_d  = wr_idx_q;
    served_d  = served_q;
    status_d  = status_q;
    mem_req_o = '{we: 1'b0, waddr: wr_idx_q, wdata: mem_rdata_i, raddr: idx_q[AddrW-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        served_d = '0;
        status_d = ST_OK;
        state_d  = S_RESP;
        unique case (req_q.op)
          OP_ENQ: begin
            if (count_q == CntW'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = count_q[AddrW-1:0];
              mem_req_o.wdata = req_q.ent;
              count_d         = count_q + CntW'(1);
            end
          end
          OP_DEQ, OP_REM: begin
            if (count_q == '0) begin
              status_d = (req_q.op == OP_DEQ) ? ST_EMPTY : ST_NOT_FOUND;
            end else begin
              idx_d     = '0;
              cmp_vld_d = 1'b0;
              state_d   = S_SCAN;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        // Read address runs one ahead of the entry under compare.
        if (!cmp_vld_q) begin
          idx_d     = idx_q + CntW'(1);
          cmp_vld_d = 1'b1;
        end else if (hit) begin
          served_d  = mem_rdata_i;
          wr_idx_d  = AddrW'(idx_q - CntW'(1));
          cmp_vld_d = 1'b0;
          state_d   = S_SHIFT;
        end else if (idx_q == count_q) begin
          status_d  = ST_NOT_FOUND;
          cmp_vld_d = 1'b0;
          state_d   = S_RESP;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_SHIFT: begin
        // Move the next entry down one slot while fetching the one after it.
        mem_req_o.raddr = AddrW'(wr_idx_q + AddrW'(2));
        if ((CntW'(wr_idx_q) + CntW'(1)) < count_q) begin
          mem_req_o.we = 1'b1;
          wr_idx_d     = wr_idx_q + AddrW'(1);
        end else begin
          count_d  = count_q - CntW'(1);
          status_d = ST_OK;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = '{status: status_q, served: served_q, count: count_q};

endmodule

// File: sv/fifo_queue_with_remove_by_id_unit.sv
// Top level of the FIFO queue with remove-by-identifier.
// Depends on fqrm_pkg, fqrm_store and fqrm_seq.
//
// Bounded queue of up to QUEUE_DEPTH entries (identifier, name tag, VIP bit),
// held in queue order in a single-port-read, single-port-write store with
// the head at slot 0. Opcode 0 appends at the tail (status 3 when full),
// 1 takes the head (status 1 when empty), 2 deletes the first entry whose
// identifier matches and closes the gap (status 2 when absent), 3 is a no-op.
// Every item yields exactly one result carrying the count and empty flag
// after the operation; served fields are zero unless an entry left the queue.
// One item is in work at a time: in_stall_o stays high from acceptance until
// the sequencer hands its result to the output register. Dequeue and remove
// scan the store one entry per cycle through the registered read port and
// then shift each later entry down one slot per cycle, so their run grows
// with the number of entries held. The output register lets the next item
// be accepted while a finished result still waits for the consumer.
module fifo_queue_with_remove_by_id_unit import fqrm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            opcode_i,
  input  logic [15:0]           visitor_id_i,
  input  logic [15:0]           name_tag_i,
  input  logic                  category_vip_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [15:0]           served_id_o,
  output logic [15:0]           served_tag_o,
  output logic                  served_vip_o,
  output logic [CountPortW-1:0] entry_count_o,
  output logic                  is_empty_o
);

  logic     seq_idle;
  logic     start;
  req_t     req;
  logic     rsp_valid;
  logic     rsp_take;
  rsp_t     rsp;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  logic     out_valid_q, out_valid_d;
  rsp_t     out_q;

  // Accept a new item whenever the sequencer is free.
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;
  assign req        = '{op: op_e'(opcode_i),
                        ent: '{id: visitor_id_i, tag: name_tag_i, vip: category_vip_i}};

  fqrm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .idle_o      (seq_idle),
    .rsp_valid_o (rsp_valid),
    .rsp_take_i  (rsp_take),
    .rsp_o       (rsp),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fqrm_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign rsp_take = rsp_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while stalled.
  always_ff @(posedge clk_i) begin
    if (rsp_take) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign served_id_o   = out_q.served.id;
  assign served_tag_o  = out_q.served.tag;
  assign served_vip_o  = out_q.served.vip;
  assign entry_count_o = CountPortW'(out_q.count);
  assign is_empty_o    = (out_q.count == '0);

endmodule

// File: sv/fqrm_checker.sv
// Port-level checker for the FIFO queue with remove-by-identifier, and its bind.
// Depends on fqrm_pkg and the top-level port list.
module fqrm_checker import fqrm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [15:0]           served_id_o,
  input logic [15:0]           served_tag_o,
  input logic                  served_vip_o,
  input logic [CountPortW-1:0] entry_count_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(served_id_o) && $stable(served_tag_o) && $stable(served_vip_o) &&
      $stable(entry_count_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= CountPortW'(QUEUE_DEPTH))
    else $error("count above queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == CountPortW'(QUEUE_DEPTH))
    else $error("full reported below depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> entry_count_o == '0)
    else $error("empty reported with entries held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      served_id_o == '0 && served_tag_o == '0 && !served_vip_o)
    else $error("served fields set on a failed operation");

endmodule

bind fifo_queue_with_remove_by_id_unit fqrm_checker u_fqrm_checker (.*);

// File: dv/fqrm_queue_shadow.sv
// Shadow model and result check for the FIFO queue with remove-by-identifier.
// Depends on fqrm_pkg; watches both item channels of the block and counts
// every result field that differs from the shadow queue's prediction, and every unexpected result.
module fqrm_queue_shadow import fqrm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            opcode_i,
  input  logic [15:0]           visitor_id_i,
  input  logic [15:0]           name_tag_i,
  input  logic                  category_vip_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            status_i,
  input  logic [15:0]           served_id_i,
  input  logic [15:0]           served_tag_i,
  input  logic                  served_vip_i,
  input  logic [CountPortW-1:0] entry_count_i,
  input  logic                  is_empty_i,
  output int                    mismatch_count_o,
  output int                    pending_o,
  output int                    items_seen_o,
  output int                    results_seen_o,
  output int                    full_hits_o,
  output int                    removals_o
);

  typedef struct {
    status_e               status;
    entry_t                served;
    logic [CountPortW-1:0] count;
    logic                  empty;
  } visitor_result_t;

  entry_t          held_q[$];
  visitor_result_t result_q[$];
  visitor_result_t oldest;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    items_seen_o     = 0;
    results_seen_o   = 0;
    full_hits_o      = 0;
    removals_o       = 0;
  end

  // Apply one operation to the shadow queue and return the result it gives.
  function automatic visitor_result_t apply_visitor_op(op_e op, entry_t ent);
    visitor_result_t r;
    int              hit;
    r.status = ST_OK;
    r.served = '0;
    hit      = -1;
    case (op)
      OP_ENQ: begin
        if (held_q.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else held_q.push_back(ent);
      end
      OP_DEQ: begin
        if (held_q.size() == 0) r.status = ST_EMPTY;
        else r.served = held_q.pop_front();
      end
      OP_REM: begin
        // first match nearest the head wins
        for (int i = 0; i < held_q.size() && hit < 0; i++) begin
          if (held_q[i].id == ent.id) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.served = held_q[hit];
          held_q.delete(hit);
        end
      end
      default: ;
    endcase
    r.count = CountPortW'(held_q.size());
    r.empty = (held_q.size() == 0);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count_o = mismatch_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.delete();
      result_q.delete();
      pending_o = 0;
    end else begin
      // check results first: an item taken at this edge cannot finish at it
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        results_seen_o = results_seen_o + 1;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0h id %0h",
                   $time, status_i, served_id_i);
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          oldest = result_q.pop_front();
          flag_field("status", 16'(oldest.status), 16'(status_i));
          flag_field("served_id", oldest.served.id, served_id_i);
          flag_field("served_tag", oldest.served.tag, served_tag_i);
          flag_field("served_vip", 16'(oldest.served.vip), 16'(served_vip_i));
          flag_field("entry_count", 16'(oldest.count), 16'(entry_count_i));
          flag_field("is_empty", 16'(oldest.empty), 16'(is_empty_i));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        oldest = apply_visitor_op(op_e'(opcode_i),
                                  entry_t'({visitor_id_i, name_tag_i, category_vip_i}));
        if (oldest.status == ST_FULL) full_hits_o = full_hits_o + 1;
        if (op_e'(opcode_i) == OP_REM && oldest.status == ST_OK)
          removals_o = removals_o + 1;
        result_q.push_back(oldest);
        items_seen_o = items_seen_o + 1;
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: dv/fifo_queue_with_remove_by_id_unit_test.sv
// Test top for the FIFO queue with remove-by-identifier: clock, reset, item
// stimulus, receiver stalls and the verdict. Depends on fqrm_pkg, the block
// and fqrm_queue_shadow, which predicts and checks every result.
module fifo_queue_with_remove_by_id_unit_test;
  import fqrm_pkg::*;

  localparam int RANDOM_ITEMS   = 600;
  localparam int BACKLOG_CYCLES = 120;
  localparam int TIMEOUT_UNITS  = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            opcode_i;
  logic [15:0]           visitor_id_i;
  logic [15:0]           name_tag_i;
  logic                  category_vip_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            status_o;
  logic [15:0]           served_id_o;
  logic [15:0]           served_tag_o;
  logic                  served_vip_o;
  logic [CountPortW-1:0] entry_count_o;
  logic                  is_empty_o;

  int fail_count;
  int pending;
  int items_seen;
  int results_seen;
  int full_hits;
  int removals;

  // Shared between stimulus and receiver. quiet_stretch turns off idling on
  // both sides; backlog_req asks the receiver for one long hold-off and is
  // cleared by the receiver when the hold-off is over.
  logic quiet_stretch = 1'b0;
  logic backlog_req   = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fifo_queue_with_remove_by_id_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .visitor_id_i,
    .name_tag_i,
    .category_vip_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .served_id_o,
    .served_tag_o,
    .served_vip_o,
    .entry_count_o,
    .is_empty_o
  );

  fqrm_queue_shadow shadow (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .opcode_i,
    .visitor_id_i,
    .name_tag_i,
    .category_vip_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .status_i         (status_o),
    .served_id_i      (served_id_o),
    .served_tag_i     (served_tag_o),
    .served_vip_i     (served_vip_o),
    .entry_count_i    (entry_count_o),
    .is_empty_i       (is_empty_o),
    .mismatch_count_o (fail_count),
    .pending_o        (pending),
    .items_seen_o     (items_seen),
    .results_seen_o   (results_seen),
    .full_hits_o      (full_hits),
    .removals_o       (removals)
  );

  // Offer one item. Drive at the falling edge, optionally idle first, then
  // hold the payload until a rising edge sees the block not stalling.
  task automatic offer_item(input op_e op, input logic [15:0] id,
                            input logic [15:0] tag, input logic vip);
    @(negedge clk_i);
    if (!quiet_stretch && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    visitor_id_i   <= id;
    name_tag_i     <= tag;
    category_vip_i <= vip;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Receiver: stall at random, except in the quiet stretch; on request hold
  // off for a long run of cycles so the block backs up and stalls its input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (backlog_req) begin
        out_stall_i <= 1'b1;
        repeat (BACKLOG_CYCLES) @(negedge clk_i);
        backlog_req = 1'b0;
      end
      out_stall_i <= !quiet_stretch && ($urandom_range(0, 99) < 18);
    end
  end

  initial begin : stimulus
    logic [15:0] pick_id;
    logic [15:0] pick_tag;
    op_e         op;
    int          roll;
    logic        fill_bias;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_IGNORE;
    visitor_id_i   = '0;
    name_tag_i     = '0;
    category_vip_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue: dequeue, remove with no match, unused opcode.
    offer_item(OP_DEQ, 16'h0000, 16'h0000, 1'b0);
    offer_item(OP_REM, 16'hFFFF, 16'hFFFF, 1'b1);
    offer_item(OP_IGNORE, 16'h1234, 16'h5678, 1'b1);

    // Fill to the brim. Extremes sit at the head, and identifier 5 appears
    // twice so a removal has to pick the copy nearest the head.
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      pick_id  = (k == 1) ? 16'hFFFF : (k == 9) ? 16'h0005 : 16'(k);
      pick_tag = (k == 1) ? 16'hFFFF : 16'(k * 16'h1111);
      offer_item(OP_ENQ, pick_id, pick_tag, k[0]);
    end
    // Enqueue into a full queue must be refused.
    offer_item(OP_ENQ, 16'h0042, 16'hA5A5, 1'b1);

    // Removals: both duplicates, an entry near the head, the tail, a miss.
    offer_item(OP_REM, 16'h0005, 16'h0000, 1'b0);
    offer_item(OP_REM, 16'h0005, 16'h0000, 1'b0);
    offer_item(OP_REM, 16'hFFFF, 16'h0000, 1'b0);
    offer_item(OP_REM, 16'h000F, 16'h0000, 1'b0);
    offer_item(OP_REM, 16'hBEEF, 16'h0000, 1'b0);
    offer_item(OP_DEQ, 16'h0000, 16'h0000, 1'b0);
    offer_item(OP_IGNORE, 16'hFFFF, 16'hFFFF, 1'b1);

    // Random part. Alternate fill-leaning and drain-leaning blocks so the
    // queue swings between empty and full; keep most identifiers in a small
    // range so removals usually hit and duplicates are common.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_stretch = (n >= 150 && n < 250);
      if (n == 400) backlog_req = 1'b1;
      fill_bias = ((n / 40) % 2 == 0);
      roll = $urandom_range(0, 99);
      if (roll < 5) op = OP_IGNORE;
      else if (roll < (fill_bias ? 65 : 35)) op = OP_ENQ;
      else if (roll < (fill_bias ? 80 : 65)) op = OP_DEQ;
      else op = OP_REM;
      pick_id  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      pick_tag = 16'($urandom);
      offer_item(op, pick_id, pick_tag, 1'($urandom));
    end
    quiet_stretch = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain: wait for every predicted result, then a little longer to catch
    // anything extra the block might still produce.
    while (pending != 0) @(negedge clk_i);
    repeat (QUEUE_DEPTH + 8) @(negedge clk_i);

    $display("Run covered %0d items and %0d results, %0d successful removals,",
             items_seen, results_seen, removals);
    $display("%0d refused enqueues on a full queue, %0d mismatches.", full_hits, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("Timeout with %0d results still outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
